// File: src/bms_pkg.sv
// bms_pkg: shared constants, types and state encoding for block_mean_stddev
`default_nettype none
package bms_pkg;

  localparam int BLOCK_LEN = 16;

  localparam int SAMPLE_W = 12;
  localparam int OUT_W    = 20;
  localparam int CNT_W    = $clog2(BLOCK_LEN);
  localparam int SUM_W    = SAMPLE_W + CNT_W;
  localparam int SQ_W     = 2 * SAMPLE_W + CNT_W;
  localparam int NUM_W    = 2 * SUM_W;
  localparam int RAD_W    = NUM_W + 16;
  localparam int RT_W     = RAD_W / 2;
  localparam int MEAN_W   = SUM_W + 8;
  localparam int DEN_W    = $clog2(BLOCK_LEN * (BLOCK_LEN - 1) + 1);
  localparam int SR_W     = RAD_W + DEN_W;
  localparam int ITER_W   = $clog2(RT_W);

  // root search terms carry the variance divisor, so no division is needed
  localparam logic [SR_W-1:0] VAR_DEN = SR_W'(BLOCK_LEN * (BLOCK_LEN - 1));
  localparam logic [SR_W-1:0] SQRT_E0 = VAR_DEN << (2 * (RT_W - 1));

  localparam logic [CNT_W-1:0]  LAST_CNT   = CNT_W'(BLOCK_LEN - 1);
  localparam logic [ITER_W-1:0] SQRT_LAST  = ITER_W'(RT_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_VLOAD,
    ST_SQRT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic acc;        // take one sample beat into the accumulators
    logic mean_load;  // form the mean and the products for the variance
    logic var_load;   // load the radicand, clear the root search
    logic sqrt_step;  // one root digit
    logic out_load;   // move results into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic last;       // next sample closes the block
  } dp_stat_t;

endpackage
`default_nettype wire

// File: src/block_mean_stddev.sv
// block_mean_stddev: top level, controller plus datapath
//
//   channel  ports                                    handshake
//   input    in_sample[11:0]                          in_valid / in_stall
//   output   out_block_mean[19:0], out_block_stddev   out_valid / out_stall
//
// one sample beat is taken per cycle; the block-end beat is held off while the
// previous block is still being post-processed.
// post-processing steps: products, radicand load, one root bit per cycle with the
// variance divisor folded in, output load; the output load waits while the previous
// result is still held by out_stall.
// synchronous reset clears the count, sums and controller; no clearing pass.
// a stalled result waits in the output register while accumulation continues.
`default_nettype none
module block_mean_stddev (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [bms_pkg::SAMPLE_W-1:0] in_sample,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [bms_pkg::OUT_W-1:0]         out_block_mean,
  output logic [bms_pkg::OUT_W-1:0]         out_block_stddev
);

  bms_pkg::dp_cmd_t  cmd;
  bms_pkg::dp_stat_t stat;

  bms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  bms_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_sample        (in_sample),
    .cmd              (cmd),
    .stat             (stat),
    .out_block_mean   (out_block_mean),
    .out_block_stddev (out_block_stddev)
  );

endmodule
`default_nettype wire

// File: src/bms_ctrl.sv
// bms_ctrl: sequencer for accumulation handshake and block-end post-processing
`default_nettype none
module bms_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire bms_pkg::dp_stat_t stat,
  output bms_pkg::dp_cmd_t      cmd
);

  bms_pkg::state_t state_r, state_nxt;
  logic [bms_pkg::ITER_W-1:0] iter_r, iter_nxt;
  logic out_valid_r, out_valid_nxt;
  logic acc;
  logic out_free;
  logic counting;

  // block-end beat must wait until the previous block is finished
  assign in_stall  = stat.last && (state_r != bms_pkg::ST_IDLE);
  assign acc       = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bms_pkg::ST_IDLE: begin
        if (acc && stat.last) state_nxt = bms_pkg::ST_LOAD;
      end
      bms_pkg::ST_LOAD:  state_nxt = bms_pkg::ST_VLOAD;
      bms_pkg::ST_VLOAD: state_nxt = bms_pkg::ST_SQRT;
      bms_pkg::ST_SQRT: begin
        if (iter_r == bms_pkg::SQRT_LAST) state_nxt = bms_pkg::ST_OUT;
      end
      bms_pkg::ST_OUT: begin
        if (out_free) state_nxt = bms_pkg::ST_IDLE;
      end
      default: state_nxt = bms_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd     = '0;
    cmd.acc = acc;
    unique case (state_r)
      bms_pkg::ST_IDLE:  ;
      bms_pkg::ST_LOAD:  cmd.mean_load = 1'b1;
      bms_pkg::ST_VLOAD: cmd.var_load = 1'b1;
      bms_pkg::ST_SQRT:  cmd.sqrt_step = 1'b1;
      bms_pkg::ST_OUT:   cmd.out_load = out_free;
      default: ;
    endcase
  end

  assign counting = (state_r == bms_pkg::ST_SQRT);

  always_comb begin
    iter_nxt = '0;
    if (counting && (state_nxt == state_r)) iter_nxt = iter_r + 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bms_pkg::ST_IDLE;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/bms_dp.sv
// bms_dp: accumulators, scaled digit-by-digit square root, output register
`default_nettype none
module bms_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [bms_pkg::SAMPLE_W-1:0]  in_sample,
  input  wire bms_pkg::dp_cmd_t              cmd,
  output bms_pkg::dp_stat_t                  stat,
  output logic [bms_pkg::OUT_W-1:0]          out_block_mean,
  output logic [bms_pkg::OUT_W-1:0]          out_block_stddev
);

  localparam int SUM_W  = bms_pkg::SUM_W;
  localparam int SQ_W   = bms_pkg::SQ_W;
  localparam int NUM_W  = bms_pkg::NUM_W;
  localparam int RT_W   = bms_pkg::RT_W;
  localparam int SR_W   = bms_pkg::SR_W;
  localparam int OUT_W  = bms_pkg::OUT_W;
  localparam int MEAN_W = bms_pkg::MEAN_W;

  logic [bms_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt, s1_r;
  logic [SQ_W-1:0]  sq_r, sq_nxt, s2_r;
  logic [SUM_W-1:0] sum_add;
  logic [SQ_W-1:0]  sq_add;
  logic [NUM_W-1:0] prod_r, ns2_r;
  logic [SR_W-1:0]  rem_r, rem_nxt;
  logic [SR_W-1:0]  g_r, g_nxt;
  logic [SR_W-1:0]  e_r, e_nxt;
  logic [SR_W-1:0]  trial;
  logic             sge;
  logic [RT_W-1:0]  sroot_r, sroot_nxt;
  logic [OUT_W-1:0] mean_r;
  logic [OUT_W-1:0] omean_r, osd_r;

  assign stat.last = (count_r == bms_pkg::LAST_CNT);

  assign sum_add = sum_r + SUM_W'(in_sample);
  assign sq_add  = sq_r + SQ_W'(in_sample) * SQ_W'(in_sample);

  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    sq_nxt    = sq_r;
    if (cmd.acc) begin
      if (stat.last) begin
        count_nxt = '0;
        sum_nxt   = '0;
        sq_nxt    = '0;
      end else begin
        count_nxt = count_r + 1'b1;
        sum_nxt   = sum_add;
        sq_nxt    = sq_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      sq_r    <= '0;
    end else begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      sq_r    <= sq_nxt;
    end
  end

  // block totals, held while the next block accumulates
  always_ff @(posedge clk) begin
    if (cmd.acc && stat.last) begin
      s1_r <= sum_add;
      s2_r <= sq_add;
    end
  end

  // largest r with den*r*r <= radicand, one root bit per step:
  // rem = radicand - den*r*r, g = den*2*r*bit, e = den*bit*bit
  assign trial = g_r + e_r;
  assign sge   = (rem_r >= trial);

  always_comb begin
    rem_nxt   = rem_r;
    g_nxt     = g_r;
    e_nxt     = e_r;
    sroot_nxt = sroot_r;
    if (cmd.var_load) begin
      rem_nxt   = SR_W'({ns2_r - prod_r, 16'b0});
      g_nxt     = '0;
      e_nxt     = bms_pkg::SQRT_E0;
      sroot_nxt = '0;
    end else if (cmd.sqrt_step) begin
      rem_nxt   = sge ? (rem_r - trial) : rem_r;
      g_nxt     = sge ? ((g_r >> 1) + e_r) : (g_r >> 1);
      e_nxt     = e_r >> 2;
      sroot_nxt = {sroot_r[RT_W-2:0], sge};
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    g_r     <= g_nxt;
    e_r     <= e_nxt;
    sroot_r <= sroot_nxt;
    if (cmd.mean_load) begin
      mean_r <= OUT_W'({s1_r, 8'b0} / MEAN_W'(bms_pkg::BLOCK_LEN));
      prod_r <= NUM_W'(s1_r) * NUM_W'(s1_r);
      ns2_r  <= NUM_W'(bms_pkg::BLOCK_LEN) * NUM_W'(s2_r);
    end
    if (cmd.out_load) begin
      omean_r <= mean_r;
      osd_r   <= sroot_r[OUT_W-1:0];
    end
  end

  assign out_block_mean   = omean_r;
  assign out_block_stddev = osd_r;

endmodule
`default_nettype wire
